// File: hw/rtl/sprite_layer_compositor_upscale_macros.svh
// assertion macros used by the checker file
`ifndef SPRITE_LAYER_COMPOSITOR_UPSCALE_MACROS_SVH
`define SPRITE_LAYER_COMPOSITOR_UPSCALE_MACROS_SVH

// same-cycle implication, sampled on clk and switched off in reset
`define SLCU_ASSERT_IMPL(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) else $error(msg);

// next-cycle implication, sampled on clk and switched off in reset
`define SLCU_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) else $error(msg);

`endif

// File: hw/rtl/slcu_pkg.sv
// shared constants, codes and control structs of the sprite compositor
package slcu_pkg;

	localparam int DEF_FACE_SIZE    = 36;
	localparam int DEF_EYES_WIDTH   = 32;
	localparam int DEF_EYES_HEIGHT  = 16;
	localparam int DEF_MOUTH_WIDTH  = 16;
	localparam int DEF_MOUTH_HEIGHT = 8;
	localparam int DEF_SCALE        = 10;

	localparam int TILES      = 16;
	localparam int TILE_W     = 4;
	localparam int COORD_W    = 10;
	localparam int PIX_W      = 16;
	localparam int OFF_W      = 6;
	localparam int ACT_W      = 2;
	localparam int LAYER_W    = 2;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// reciprocal scaling for the divide by the scale factor
	localparam int RECIP_SHIFT = 16;

	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_COMPOSE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

	localparam logic [LAYER_W-1:0] LAYER_BASE  = 2'd0;
	localparam logic [LAYER_W-1:0] LAYER_EYES  = 2'd1;
	localparam logic [LAYER_W-1:0] LAYER_MOUTH = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_EYES_OX    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_EYES_OY    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MOUTH_OX   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MOUTH_OY   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COLOR  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_COL = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_ROW = 3'd6;

	localparam logic [PIX_W-1:0]   BLACK        = 16'h0000;
	localparam logic [COORD_W-1:0] ORIGIN_RESET = 10'd60;

	// compose request towards the paint engine
	typedef struct packed {
		logic              start;
		logic [TILE_W-1:0] base_tile;
		logic [TILE_W-1:0] eyes_tile;
		logic [TILE_W-1:0] mouth_tile;
	} cmd_t;

	// layer placement and transparency seen by the paint engine
	typedef struct packed {
		logic [OFF_W-1:0] eyes_ox;
		logic [OFF_W-1:0] eyes_oy;
		logic [OFF_W-1:0] mouth_ox;
		logic [OFF_W-1:0] mouth_oy;
		logic [PIX_W-1:0] key;
	} paint_cfg_t;

endpackage

// File: hw/rtl/slcu_if.sv
// valid/ready channel interfaces: request items, results and register writes
interface slcu_item_if;
	import slcu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ACT_W-1:0]     action;
	logic [LAYER_W-1:0]   layer;
	logic [TILE_W-1:0]    tile_number;
	logic [COORD_W-1:0]   coord_x;
	logic [COORD_W-1:0]   coord_y;
	logic [PIX_W-1:0]     pixel_value;
	logic [TILE_W-1:0]    base_tile;
	logic [TILE_W-1:0]    eyes_tile;
	logic [TILE_W-1:0]    mouth_tile;
	modport source (output valid, action, layer, tile_number, coord_x, coord_y,
		pixel_value, base_tile, eyes_tile, mouth_tile, input ready);
	modport sink (input valid, action, layer, tile_number, coord_x, coord_y,
		pixel_value, base_tile, eyes_tile, mouth_tile, output ready);
endinterface

interface slcu_result_if;
	import slcu_pkg::*;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] kind;
	logic [PIX_W-1:0] color;
	logic             covered;
	modport source (output valid, kind, color, covered, input ready);
	modport sink (input valid, kind, color, covered, output ready);
endinterface

interface slcu_cfg_if;
	import slcu_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/slcu_ram.sv
// generic single-write, single-read ram with registered read data
module slcu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/slcu_paint.sv
// paint engine: one pixel a cycle over base, eyes and mouth tiles into staging
module slcu_paint #(
	parameter int FACE_SIZE    = slcu_pkg::DEF_FACE_SIZE,
	parameter int EYES_WIDTH   = slcu_pkg::DEF_EYES_WIDTH,
	parameter int EYES_HEIGHT  = slcu_pkg::DEF_EYES_HEIGHT,
	parameter int MOUTH_WIDTH  = slcu_pkg::DEF_MOUTH_WIDTH,
	parameter int MOUTH_HEIGHT = slcu_pkg::DEF_MOUTH_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  slcu_pkg::cmd_t            cmd,
	input  slcu_pkg::paint_cfg_t      pcfg,
	output logic                      busy,
	output logic [$clog2(slcu_pkg::TILES*FACE_SIZE*FACE_SIZE)-1:0]     base_raddr,
	input  logic [slcu_pkg::PIX_W-1:0]                                  base_rdata,
	output logic [$clog2(slcu_pkg::TILES*EYES_WIDTH*EYES_HEIGHT)-1:0]  eyes_raddr,
	input  logic [slcu_pkg::PIX_W-1:0]                                  eyes_rdata,
	output logic [$clog2(slcu_pkg::TILES*MOUTH_WIDTH*MOUTH_HEIGHT)-1:0] mouth_raddr,
	input  logic [slcu_pkg::PIX_W-1:0]                                  mouth_rdata,
	output logic                                   stg_we,
	output logic [$clog2(FACE_SIZE*FACE_SIZE)-1:0] stg_waddr,
	output logic [slcu_pkg::PIX_W-1:0]             stg_wdata
);
	import slcu_pkg::*;

	localparam logic [1:0] PH_BASE  = 2'd0;
	localparam logic [1:0] PH_EYES  = 2'd1;
	localparam logic [1:0] PH_MOUTH = 2'd2;

	localparam int MAX_A = (FACE_SIZE > EYES_WIDTH) ? FACE_SIZE : EYES_WIDTH;
	localparam int MAX_B = (EYES_HEIGHT > MOUTH_WIDTH) ? EYES_HEIGHT : MOUTH_WIDTH;
	localparam int MAX_C = (MAX_A > MAX_B) ? MAX_A : MAX_B;
	localparam int MAXD  = (MAX_C > MOUTH_HEIGHT) ? MAX_C : MOUTH_HEIGHT;
	localparam int CW    = $clog2(MAXD);
	localparam int DW    = ((CW > OFF_W) ? CW : OFF_W) + 1;
	localparam int SAW   = $clog2(FACE_SIZE*FACE_SIZE);
	localparam int BAW   = $clog2(TILES*FACE_SIZE*FACE_SIZE);
	localparam int EAW   = $clog2(TILES*EYES_WIDTH*EYES_HEIGHT);
	localparam int MAW   = $clog2(TILES*MOUTH_WIDTH*MOUTH_HEIGHT);
	localparam int AWX   = (BAW > EAW) ? BAW : EAW;
	localparam int AWM   = (AWX > MAW) ? AWX : MAW;

	// issue side
	logic           running_q;
	logic [1:0]     phase_q;
	logic [CW-1:0]  x_q;
	logic [CW-1:0]  y_q;
	logic [AWM-1:0] addr_q;
	logic [AWM-1:0] row_q;

	// atlas data returns
	logic           v_s1;
	logic [1:0]     ph_s1;
	logic           in_s1;
	logic [DW-1:0]  dx_s1;
	logic [DW-1:0]  dy_s1;

	// staging write
	logic             we_s2;
	logic [SAW-1:0]   addr_s2;
	logic [PIX_W-1:0] data_s2;

	logic [CW-1:0]    w_last;
	logic [CW-1:0]    h_last;
	logic [AWM-1:0]   stride;
	logic [OFF_W-1:0] ox;
	logic [OFF_W-1:0] oy;
	logic [AWM-1:0]   next_start;
	logic [DW-1:0]    dx_c;
	logic [DW-1:0]    dy_c;
	logic             in_c;
	logic [PIX_W-1:0] pix;
	logic             is_key;
	logic             row_end;
	logic             tile_end;

	always_comb begin
		case (phase_q)
			PH_EYES: begin
				w_last     = CW'(EYES_WIDTH - 1);
				h_last     = CW'(EYES_HEIGHT - 1);
				stride     = AWM'(TILES * EYES_WIDTH);
				ox         = pcfg.eyes_ox;
				oy         = pcfg.eyes_oy;
				next_start = AWM'(int'(cmd.mouth_tile) * MOUTH_WIDTH);
			end
			PH_MOUTH: begin
				w_last     = CW'(MOUTH_WIDTH - 1);
				h_last     = CW'(MOUTH_HEIGHT - 1);
				stride     = AWM'(TILES * MOUTH_WIDTH);
				ox         = pcfg.mouth_ox;
				oy         = pcfg.mouth_oy;
				next_start = AWM'(int'(cmd.mouth_tile) * MOUTH_WIDTH);
			end
			default: begin
				w_last     = CW'(FACE_SIZE - 1);
				h_last     = CW'(FACE_SIZE - 1);
				stride     = AWM'(TILES * FACE_SIZE);
				ox         = '0;
				oy         = '0;
				next_start = AWM'(int'(cmd.eyes_tile) * EYES_WIDTH);
			end
		endcase
	end

	assign row_end  = (x_q == w_last);
	assign tile_end = row_end && (y_q == h_last);
	assign dx_c     = DW'(ox) + DW'(x_q);
	assign dy_c     = DW'(oy) + DW'(y_q);
	assign in_c     = (int'(dx_c) < FACE_SIZE) && (int'(dy_c) < FACE_SIZE);

	assign base_raddr  = addr_q[BAW-1:0];
	assign eyes_raddr  = addr_q[EAW-1:0];
	assign mouth_raddr = addr_q[MAW-1:0];

	always_comb begin
		case (ph_s1)
			PH_EYES:  pix = eyes_rdata;
			PH_MOUTH: pix = mouth_rdata;
			default:  pix = base_rdata;
		endcase
	end

	assign is_key = (pix == pcfg.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= PH_BASE;
			x_q       <= '0;
			y_q       <= '0;
			addr_q    <= '0;
			row_q     <= '0;
			v_s1      <= 1'b0;
			we_s2     <= 1'b0;
		end else begin
			v_s1  <= running_q;
			we_s2 <= v_s1 && ((ph_s1 == PH_BASE) || (!is_key && in_s1));
			if (cmd.start) begin
				running_q <= 1'b1;
				phase_q   <= PH_BASE;
				x_q       <= '0;
				y_q       <= '0;
				addr_q    <= AWM'(int'(cmd.base_tile) * FACE_SIZE);
				row_q     <= AWM'(int'(cmd.base_tile) * FACE_SIZE);
			end else if (running_q) begin
				if (tile_end) begin
					x_q    <= '0;
					y_q    <= '0;
					addr_q <= next_start;
					row_q  <= next_start;
					if (phase_q == PH_MOUTH) begin
						running_q <= 1'b0;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end else if (row_end) begin
					x_q    <= '0;
					y_q    <= y_q + CW'(1);
					addr_q <= row_q + stride;
					row_q  <= row_q + stride;
				end else begin
					x_q    <= x_q + CW'(1);
					addr_q <= addr_q + AWM'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ph_s1   <= phase_q;
		in_s1   <= in_c;
		dx_s1   <= dx_c;
		dy_s1   <= dy_c;
		addr_s2 <= SAW'(int'(dy_s1) * FACE_SIZE + int'(dx_s1));
		data_s2 <= is_key ? BLACK : pix;
	end

	assign busy      = running_q | v_s1 | we_s2;
	assign stg_we    = we_s2;
	assign stg_waddr = addr_s2;
	assign stg_wdata = data_s2;

endmodule

// File: hw/rtl/sprite_layer_compositor_upscale.sv
// top level of the colour-key sprite compositor with nearest-neighbour upscale
// Three atlases (base, eyes, mouth) of sixteen tiles in one row are loaded a
// pixel per load item; a compose item builds the FACE_SIZE square staging image
// from one base tile (key pixels turn black) with the eye and mouth tiles painted
// over it at the offsets held in the registers (key pixels skipped, pixels past
// the staging edge clipped); a read item maps a panel coordinate back through
// the SCALE factor about the origin registers and returns that staging pixel
// with covered set, or black with covered clear outside the face. One item is
// worked on at a time and item ready is high only while the sequencer is idle.
// A load runs through accept, ram write and result. A read runs through origin
// subtract and range check, reciprocal multiply, quotient correction, staging
// address, ram read, data capture and result. A compose lasts as long as the
// single paint engine needs to move the base, eyes and mouth tiles into staging,
// one atlas pixel per cycle. An unknown action goes straight to the result.
// After reset the staging ram is swept to black, one entry a cycle, before the
// first item is taken; register writes are taken at any time. The result sits
// in an output register so the next item can be taken while a result still
// waits for its transfer. Atlas entries must be loaded before a compose uses
// them.
module sprite_layer_compositor_upscale #(
	parameter int FACE_SIZE    = slcu_pkg::DEF_FACE_SIZE,
	parameter int EYES_WIDTH   = slcu_pkg::DEF_EYES_WIDTH,
	parameter int EYES_HEIGHT  = slcu_pkg::DEF_EYES_HEIGHT,
	parameter int MOUTH_WIDTH  = slcu_pkg::DEF_MOUTH_WIDTH,
	parameter int MOUTH_HEIGHT = slcu_pkg::DEF_MOUTH_HEIGHT,
	parameter int SCALE        = slcu_pkg::DEF_SCALE
) (
	input  logic          clk,
	input  logic          arst_n,
	slcu_item_if.sink     item,
	slcu_result_if.source result,
	slcu_cfg_if.sink      cfg
);
	import slcu_pkg::*;

	// sequencer states
	localparam logic [3:0] ST_CLEAR     = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_LOAD      = 4'd2;
	localparam logic [3:0] ST_COMP_GO   = 4'd3;
	localparam logic [3:0] ST_COMP_WAIT = 4'd4;
	localparam logic [3:0] ST_RD_SUB    = 4'd5;
	localparam logic [3:0] ST_RD_MUL    = 4'd6;
	localparam logic [3:0] ST_RD_FIX    = 4'd7;
	localparam logic [3:0] ST_RD_ADR    = 4'd8;
	localparam logic [3:0] ST_RD_RAM    = 4'd9;
	localparam logic [3:0] ST_RD_DATA   = 4'd10;
	localparam logic [3:0] ST_DONE      = 4'd11;

	localparam int SW      = $clog2(FACE_SIZE);
	localparam int SAW     = $clog2(FACE_SIZE*FACE_SIZE);
	localparam int BAW     = $clog2(TILES*FACE_SIZE*FACE_SIZE);
	localparam int EAW     = $clog2(TILES*EYES_WIDTH*EYES_HEIGHT);
	localparam int MAW     = $clog2(TILES*MOUTH_WIDTH*MOUTH_HEIGHT);
	localparam int SPAN    = FACE_SIZE * SCALE;
	localparam int RECIP   = (1 << RECIP_SHIFT) / SCALE;
	localparam int RECIP_W = RECIP_SHIFT + 1;
	localparam int PROD_W  = COORD_W + RECIP_W;

	logic [3:0] state_q;
	logic [SAW-1:0] clr_q;

	// captured item
	logic [ACT_W-1:0]   act_q;
	logic [LAYER_W-1:0] layer_q;
	logic [TILE_W-1:0]  tile_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [PIX_W-1:0]   pix_q;
	logic [TILE_W-1:0]  bt_q;
	logic [TILE_W-1:0]  et_q;
	logic [TILE_W-1:0]  mt_q;

	// registers
	logic [OFF_W-1:0]   eox_q;
	logic [OFF_W-1:0]   eoy_q;
	logic [OFF_W-1:0]   mox_q;
	logic [OFF_W-1:0]   moy_q;
	logic [PIX_W-1:0]   key_q;
	logic [COORD_W-1:0] ocol_q;
	logic [COORD_W-1:0] orow_q;

	// read path
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic               cov_q;
	logic [COORD_W-1:0] qx_q;
	logic [COORD_W-1:0] qy_q;
	logic [SW-1:0]      sx_q;
	logic [SW-1:0]      sy_q;
	logic [SAW-1:0]     rd_addr_q;

	// pending and presented result
	logic [PIX_W-1:0] pend_color_q;
	logic             pend_cov_q;
	logic             res_valid_q;
	logic [ACT_W-1:0] res_kind_q;
	logic [PIX_W-1:0] res_color_q;
	logic             res_cov_q;

	logic               in_acc;
	logic               cfg_acc;
	logic               slot_free;
	logic [COORD_W:0]   dxw;
	logic [COORD_W:0]   dyw;
	logic               in_face;
	logic [PROD_W-1:0]  prod_x;
	logic [PROD_W-1:0]  prod_y;
	logic [COORD_W:0]   rx;
	logic [COORD_W:0]   ry;
	logic [COORD_W-1:0] qx_fix;
	logic [COORD_W-1:0] qy_fix;

	// atlas write side
	logic            base_we;
	logic            eyes_we;
	logic            mouth_we;
	logic [BAW-1:0]  base_waddr;
	logic [EAW-1:0]  eyes_waddr;
	logic [MAW-1:0]  mouth_waddr;
	logic [BAW-1:0]  base_raddr;
	logic [EAW-1:0]  eyes_raddr;
	logic [MAW-1:0]  mouth_raddr;
	logic [PIX_W-1:0] base_rdata;
	logic [PIX_W-1:0] eyes_rdata;
	logic [PIX_W-1:0] mouth_rdata;

	// staging side
	logic             p_we;
	logic [SAW-1:0]   p_waddr;
	logic [PIX_W-1:0] p_wdata;
	logic             stg_we;
	logic [SAW-1:0]   stg_waddr;
	logic [PIX_W-1:0] stg_wdata;
	logic [PIX_W-1:0] stg_rdata;

	cmd_t       cmd;
	paint_cfg_t pcfg;
	logic       paint_busy;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign in_acc     = item.valid && item.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign slot_free  = !res_valid_q || result.ready;

	// offset from the origin, borrow in the top bit means left of or above it
	assign dxw     = {1'b0, cx_q} - {1'b0, ocol_q};
	assign dyw     = {1'b0, cy_q} - {1'b0, orow_q};
	assign in_face = (dxw < (COORD_W+1)'(SPAN)) && (dyw < (COORD_W+1)'(SPAN));

	// quotient estimate by reciprocal, at most one short
	assign prod_x = PROD_W'(dx_q) * PROD_W'(RECIP);
	assign prod_y = PROD_W'(dy_q) * PROD_W'(RECIP);
	assign rx     = (COORD_W+1)'(int'(dx_q) - int'(qx_q) * SCALE);
	assign ry     = (COORD_W+1)'(int'(dy_q) - int'(qy_q) * SCALE);
	assign qx_fix = (rx >= (COORD_W+1)'(SCALE)) ? qx_q + COORD_W'(1) : qx_q;
	assign qy_fix = (ry >= (COORD_W+1)'(SCALE)) ? qy_q + COORD_W'(1) : qy_q;

	// load addressing, pixels outside the tile are dropped
	assign base_waddr  = BAW'(int'(cy_q) * (TILES*FACE_SIZE) + int'(tile_q) * FACE_SIZE
		+ int'(cx_q));
	assign eyes_waddr  = EAW'(int'(cy_q) * (TILES*EYES_WIDTH) + int'(tile_q) * EYES_WIDTH
		+ int'(cx_q));
	assign mouth_waddr = MAW'(int'(cy_q) * (TILES*MOUTH_WIDTH) + int'(tile_q) * MOUTH_WIDTH
		+ int'(cx_q));
	assign base_we  = (state_q == ST_LOAD) && (layer_q == LAYER_BASE)
		&& (int'(cx_q) < FACE_SIZE) && (int'(cy_q) < FACE_SIZE);
	assign eyes_we  = (state_q == ST_LOAD) && (layer_q == LAYER_EYES)
		&& (int'(cx_q) < EYES_WIDTH) && (int'(cy_q) < EYES_HEIGHT);
	assign mouth_we = (state_q == ST_LOAD) && (layer_q == LAYER_MOUTH)
		&& (int'(cx_q) < MOUTH_WIDTH) && (int'(cy_q) < MOUTH_HEIGHT);

	// staging write: clearing sweep after reset, paint engine otherwise
	assign stg_we    = (state_q == ST_CLEAR) ? 1'b1 : p_we;
	assign stg_waddr = (state_q == ST_CLEAR) ? clr_q : p_waddr;
	assign stg_wdata = (state_q == ST_CLEAR) ? BLACK : p_wdata;

	assign cmd.start      = (state_q == ST_COMP_GO);
	assign cmd.base_tile  = bt_q;
	assign cmd.eyes_tile  = et_q;
	assign cmd.mouth_tile = mt_q;

	assign pcfg.eyes_ox  = eox_q;
	assign pcfg.eyes_oy  = eoy_q;
	assign pcfg.mouth_ox = mox_q;
	assign pcfg.mouth_oy = moy_q;
	assign pcfg.key      = key_q;

	slcu_ram #(.WIDTH(PIX_W), .DEPTH(TILES*FACE_SIZE*FACE_SIZE)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (base_waddr),
		.wdata (pix_q),
		.raddr (base_raddr),
		.rdata (base_rdata)
	);

	slcu_ram #(.WIDTH(PIX_W), .DEPTH(TILES*EYES_WIDTH*EYES_HEIGHT)) u_eyes_ram (
		.clk   (clk),
		.we    (eyes_we),
		.waddr (eyes_waddr),
		.wdata (pix_q),
		.raddr (eyes_raddr),
		.rdata (eyes_rdata)
	);

	slcu_ram #(.WIDTH(PIX_W), .DEPTH(TILES*MOUTH_WIDTH*MOUTH_HEIGHT)) u_mouth_ram (
		.clk   (clk),
		.we    (mouth_we),
		.waddr (mouth_waddr),
		.wdata (pix_q),
		.raddr (mouth_raddr),
		.rdata (mouth_rdata)
	);

	slcu_ram #(.WIDTH(PIX_W), .DEPTH(FACE_SIZE*FACE_SIZE)) u_stage_ram (
		.clk   (clk),
		.we    (stg_we),
		.waddr (stg_waddr),
		.wdata (stg_wdata),
		.raddr (rd_addr_q),
		.rdata (stg_rdata)
	);

	slcu_paint #(
		.FACE_SIZE    (FACE_SIZE),
		.EYES_WIDTH   (EYES_WIDTH),
		.EYES_HEIGHT  (EYES_HEIGHT),
		.MOUTH_WIDTH  (MOUTH_WIDTH),
		.MOUTH_HEIGHT (MOUTH_HEIGHT)
	) u_paint (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pcfg        (pcfg),
		.busy        (paint_busy),
		.base_raddr  (base_raddr),
		.base_rdata  (base_rdata),
		.eyes_raddr  (eyes_raddr),
		.eyes_rdata  (eyes_rdata),
		.mouth_raddr (mouth_raddr),
		.mouth_rdata (mouth_rdata),
		.stg_we      (p_we),
		.stg_waddr   (p_waddr),
		.stg_wdata   (p_wdata)
	);

	// sequencer, clear counter, result valid and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			eox_q       <= '0;
			eoy_q       <= '0;
			mox_q       <= '0;
			moy_q       <= '0;
			key_q       <= BLACK;
			ocol_q      <= ORIGIN_RESET;
			orow_q      <= ORIGIN_RESET;
		end else begin
			if (cfg_acc) begin
				case (cfg.index)
					REG_EYES_OX:    eox_q  <= cfg.data[OFF_W-1:0];
					REG_EYES_OY:    eoy_q  <= cfg.data[OFF_W-1:0];
					REG_MOUTH_OX:   mox_q  <= cfg.data[OFF_W-1:0];
					REG_MOUTH_OY:   moy_q  <= cfg.data[OFF_W-1:0];
					REG_KEY_COLOR:  key_q  <= cfg.data[PIX_W-1:0];
					REG_ORIGIN_COL: ocol_q <= cfg.data[COORD_W-1:0];
					REG_ORIGIN_ROW: orow_q <= cfg.data[COORD_W-1:0];
					default: ;
				endcase
			end

			if ((state_q == ST_DONE) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SAW'(1);
					if (clr_q == SAW'(FACE_SIZE*FACE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (item.action)
							ACT_LOAD:    state_q <= ST_LOAD;
							ACT_COMPOSE: state_q <= ST_COMP_GO;
							ACT_READ:    state_q <= ST_RD_SUB;
							default:     state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOAD:      state_q <= ST_DONE;
				ST_COMP_GO:   state_q <= ST_COMP_WAIT;
				ST_COMP_WAIT: begin
					if (!paint_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_RD_SUB:  state_q <= ST_RD_MUL;
				ST_RD_MUL:  state_q <= ST_RD_FIX;
				ST_RD_FIX:  state_q <= ST_RD_ADR;
				ST_RD_ADR:  state_q <= ST_RD_RAM;
				ST_RD_RAM:  state_q <= ST_RD_DATA;
				ST_RD_DATA: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, read datapath and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q        <= item.action;
			layer_q      <= item.layer;
			tile_q       <= item.tile_number;
			cx_q         <= item.coord_x;
			cy_q         <= item.coord_y;
			pix_q        <= item.pixel_value;
			bt_q         <= item.base_tile;
			et_q         <= item.eyes_tile;
			mt_q         <= item.mouth_tile;
			pend_color_q <= BLACK;
			pend_cov_q   <= 1'b0;
		end
		if (state_q == ST_RD_SUB) begin
			dx_q  <= dxw[COORD_W-1:0];
			dy_q  <= dyw[COORD_W-1:0];
			cov_q <= in_face;
		end
		if (state_q == ST_RD_MUL) begin
			qx_q <= prod_x[RECIP_SHIFT +: COORD_W];
			qy_q <= prod_y[RECIP_SHIFT +: COORD_W];
		end
		if (state_q == ST_RD_FIX) begin
			sx_q <= qx_fix[SW-1:0];
			sy_q <= qy_fix[SW-1:0];
		end
		if (state_q == ST_RD_ADR) begin
			rd_addr_q <= SAW'(int'(sy_q) * FACE_SIZE + int'(sx_q));
		end
		if (state_q == ST_RD_DATA) begin
			// outside the face the answer is black and not covered
			pend_color_q <= cov_q ? stg_rdata : BLACK;
			pend_cov_q   <= cov_q;
		end
		if ((state_q == ST_DONE) && slot_free) begin
			res_kind_q  <= act_q;
			res_color_q <= pend_color_q;
			res_cov_q   <= pend_cov_q;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.kind    = res_kind_q;
	assign result.color   = res_color_q;
	assign result.covered = res_cov_q;

endmodule

// File: hw/rtl/slcu_chk.sv
// port-level checker for the sprite compositor and its bind
`include "sprite_layer_compositor_upscale_macros.svh"

module slcu_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [slcu_pkg::ACT_W-1:0]    res_kind,
	input logic [slcu_pkg::PIX_W-1:0]    res_color,
	input logic                          res_covered
);
	import slcu_pkg::*;

	// a stalled result keeps its payload
	`SLCU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_color) && $stable(res_covered), "result changed while stalled")

	// only a panel read can report coverage
	`SLCU_ASSERT_IMPL(a_cov_read, res_valid && res_covered, res_kind == ACT_READ, "covered on a result that is not a read")

	// an uncovered answer is always black
	`SLCU_ASSERT_IMPL(a_black_out, res_valid && !res_covered, res_color == BLACK, "colour without coverage")

	// one item in flight: ready drops after every transfer in
	`SLCU_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while another is in work")

endmodule

bind sprite_layer_compositor_upscale slcu_chk u_slcu_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_kind    (result.kind),
	.res_color   (result.color),
	.res_covered (result.covered)
);
